[sv/dgt_pkg.sv]
// shared types, constants and helper functions for the depth grid triangulator
// no dependencies; used by every module of the block through scoped names
package dgt_pkg;

    localparam int DEPTH_W = 11;
    localparam int STEP_W  = 7;
    localparam int VID_W   = 19;
    localparam int FID_W   = 20;
    localparam int X_W     = 10;
    localparam int Y_W     = 9;
    localparam int Z_W     = 12;

    localparam int IMAGE_WIDTH_DEF  = 640;
    localparam int IMAGE_HEIGHT_DEF = 480;

    localparam logic [DEPTH_W-1:0] INVALID_DEPTH = 11'd2047;
    localparam logic [Z_W-1:0]     DEPTH_OFFSET  = 12'd330;

    // apb register map
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_SAMPLE_STEP = 1'd0;
    localparam logic [STEP_W-1:0] STEP_RESET      = 7'd1;

    // record kinds
    localparam logic REC_VERTEX = 1'b0;
    localparam logic REC_FACE   = 1'b1;

    // slots of a record bundle
    localparam int SLOT_VTX    = 0;
    localparam int SLOT_FACE_A = 1;
    localparam int SLOT_FACE_B = 2;
    localparam int SLOTS       = 3;

    localparam logic [VID_W-1:0] VID_MAX = '1;
    localparam logic [FID_W-1:0] FID_MAX = '1;

    // one item after the vertex stage
    typedef struct packed {
        logic              vtx;
        logic              restart;
        logic              square;
        logic              parity;
        logic [VID_W-1:0]  cur;
        logic [VID_W-1:0]  left_cur;
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic [Z_W-1:0]    z;
    } t_item;

    typedef struct packed {
        logic [VID_W-1:0] c1;
        logic [VID_W-1:0] c2;
        logic [VID_W-1:0] c3;
    } t_corners;

    // all records caused by one item
    typedef struct packed {
        logic [SLOTS-1:0]  mask;
        logic [VID_W-1:0]  vid;
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic [Z_W-1:0]    z;
        logic [FID_W-1:0]  id_a;
        t_corners          face_a;
        logic [FID_W-1:0]  id_b;
        t_corners          face_b;
    } t_bundle;

    function automatic logic [VID_W-1:0] vid_inc(input logic [VID_W-1:0] v);
        return (v == VID_MAX) ? VID_W'(1) : v + VID_W'(1);
    endfunction

    function automatic logic [FID_W-1:0] fid_inc(input logic [FID_W-1:0] v);
        return (v == FID_MAX) ? FID_W'(1) : v + FID_W'(1);
    endfunction

endpackage

[sv/dgt_vertex_stage.sv]
// vertex stage: grid position, vertex numbering, square parity, row-above memory
// depends on dgt_pkg
module dgt_vertex_stage #(
    parameter int IMAGE_WIDTH  = dgt_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = dgt_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [dgt_pkg::STEP_W-1:0]  i_step,
    input  logic [dgt_pkg::DEPTH_W-1:0] i_depth_value,
    input  logic                        i_frame_start,
    output dgt_pkg::t_item              o_item,
    output logic [dgt_pkg::VID_W-1:0]   o_above
);

    localparam int CW = $clog2(IMAGE_WIDTH + 128);
    localparam int RW = $clog2(IMAGE_HEIGHT + 128);
    localparam int AW = (IMAGE_WIDTH > 1) ? $clog2(IMAGE_WIDTH) : 1;

    logic [CW-1:0]               r_col, n_col, col_eff, col_sum;
    logic [RW-1:0]               r_row, n_row, row_eff, row_sum;
    logic [dgt_pkg::VID_W-1:0]   r_vc, n_vc, vbase, cur;
    logic [dgt_pkg::VID_W-1:0]   r_left_cur;
    logic                        r_par;
    logic [dgt_pkg::STEP_W-1:0]  step_eff;
    logic                        restart, vtx, square, par;
    dgt_pkg::t_item              r_item, n_item;
    logic [dgt_pkg::VID_W-1:0]   r_above;
    logic [dgt_pkg::VID_W-1:0]   mem [IMAGE_WIDTH];

    always_comb begin
        step_eff = (i_step == '0) ? dgt_pkg::STEP_W'(1) : i_step;
        col_eff  = i_frame_start ? '0 : r_col;
        row_eff  = i_frame_start ? '0 : r_row;
        restart  = (col_eff == '0) && (row_eff == '0);
        vbase    = restart ? dgt_pkg::VID_W'(1) : r_vc;
        vtx      = (i_depth_value != dgt_pkg::INVALID_DEPTH);
        cur      = vtx ? vbase : '0;
        n_vc     = vtx ? dgt_pkg::vid_inc(vbase) : vbase;
        square   = (row_eff != '0) && (col_eff != '0);
        par      = (restart ? 1'b0 : r_par) ^ square;

        // advance along the row, wrap to next grid row and then to frame start
        col_sum = col_eff + CW'(step_eff);
        row_sum = row_eff + RW'(step_eff);
        if (col_sum >= CW'(IMAGE_WIDTH)) begin
            n_col = '0;
            n_row = (row_sum >= RW'(IMAGE_HEIGHT)) ? '0 : row_sum;
        end else begin
            n_col = col_sum;
            n_row = row_eff;
        end

        n_item.vtx      = vtx;
        n_item.restart  = restart;
        n_item.square   = square;
        n_item.parity   = par;
        n_item.cur      = cur;
        n_item.left_cur = r_left_cur;
        n_item.x        = dgt_pkg::X_W'(col_eff + CW'(1));
        n_item.y        = dgt_pkg::Y_W'(row_eff + RW'(1));
        n_item.z        = dgt_pkg::Z_W'(i_depth_value) - dgt_pkg::DEPTH_OFFSET;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_vc       <= dgt_pkg::VID_W'(1);
            r_par      <= 1'b0;
            r_left_cur <= '0;
        end else if (i_accept) begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_vc       <= n_vc;
            r_par      <= par;
            r_left_cur <= cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item <= n_item;
        end
    end

    // row memory: read old entry and write the new id at the same column
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            mem[col_eff[AW-1:0]] <= cur;
            r_above              <= mem[col_eff[AW-1:0]];
        end
    end

    assign o_item  = r_item;
    assign o_above = r_above;

endmodule

[sv/dgt_face_stage.sv]
// face stage: diagonal choice, face emission and face numbering
// depends on dgt_pkg
module dgt_face_stage (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  dgt_pkg::t_item            i_item,
    input  logic [dgt_pkg::VID_W-1:0] i_above,
    output dgt_pkg::t_bundle          o_bundle
);

    logic [dgt_pkg::FID_W-1:0] r_fc, n_fc, fbase, after_a;
    logic [dgt_pkg::VID_W-1:0] r_left_above;
    logic [dgt_pkg::VID_W-1:0] a, b, c, d;
    logic                      ea, eb, both;

    always_comb begin
        a     = r_left_above;
        b     = i_item.left_cur;
        c     = i_item.cur;
        d     = i_above;
        fbase = i_item.restart ? dgt_pkg::FID_W'(1) : r_fc;

        o_bundle.face_a = '0;
        o_bundle.face_b = '0;
        ea = 1'b0;
        eb = 1'b0;
        if (i_item.square) begin
            if (i_item.parity) begin
                both = (d != '0) && (b != '0);
                ea   = both && (a != '0);
                eb   = both && (c != '0);
                o_bundle.face_a = '{c1: a, c2: b, c3: d};
                o_bundle.face_b = '{c1: b, c2: c, c3: d};
            end else begin
                both = (c != '0) && (a != '0);
                ea   = both && (b != '0);
                eb   = both && (d != '0);
                o_bundle.face_a = '{c1: a, c2: b, c3: c};
                o_bundle.face_b = '{c1: a, c2: c, c3: d};
            end
        end else begin
            both = 1'b0;
        end

        after_a = ea ? dgt_pkg::fid_inc(fbase) : fbase;
        n_fc    = eb ? dgt_pkg::fid_inc(after_a) : after_a;

        o_bundle.mask[dgt_pkg::SLOT_VTX]    = i_item.vtx;
        o_bundle.mask[dgt_pkg::SLOT_FACE_A] = ea;
        o_bundle.mask[dgt_pkg::SLOT_FACE_B] = eb;
        o_bundle.vid  = i_item.cur;
        o_bundle.x    = i_item.x;
        o_bundle.y    = i_item.y;
        o_bundle.z    = i_item.z;
        o_bundle.id_a = fbase;
        o_bundle.id_b = after_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc         <= dgt_pkg::FID_W'(1);
            r_left_above <= '0;
        end else if (i_adv) begin
            r_fc         <= n_fc;
            r_left_above <= d;
        end
    end

endmodule

[sv/dgt_record_out.sv]
// record output: holds one item's records and sends them one per transaction
// depends on dgt_pkg
module dgt_record_out (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  dgt_pkg::t_bundle          i_bundle,
    input  logic                      i_out_ready,
    output logic                      o_free,
    output logic                      o_out_valid,
    output logic                      o_record_kind,
    output logic [dgt_pkg::FID_W-1:0] o_record_id,
    output logic [dgt_pkg::X_W-1:0]   o_coord_x,
    output logic [dgt_pkg::Y_W-1:0]   o_coord_y,
    output logic signed [dgt_pkg::Z_W-1:0] o_coord_z,
    output logic [dgt_pkg::VID_W-1:0] o_corner_first,
    output logic [dgt_pkg::VID_W-1:0] o_corner_second,
    output logic [dgt_pkg::VID_W-1:0] o_corner_third,
    output logic                      o_last_of_item
);

    dgt_pkg::t_bundle            r_bundle;
    logic [dgt_pkg::SLOTS-1:0]   r_mask, lowest, rest;
    logic                        take;

    always_comb begin
        lowest         = r_mask & (~r_mask + dgt_pkg::SLOTS'(1));
        rest           = r_mask & ~lowest;
        o_out_valid    = (r_mask != '0);
        take           = o_out_valid && i_out_ready;
        o_free         = !o_out_valid || (take && (rest == '0));
        o_last_of_item = (rest == '0);

        o_record_kind   = dgt_pkg::REC_FACE;
        o_record_id     = r_bundle.id_b;
        o_coord_x       = '0;
        o_coord_y       = '0;
        o_coord_z       = '0;
        o_corner_first  = r_bundle.face_b.c1;
        o_corner_second = r_bundle.face_b.c2;
        o_corner_third  = r_bundle.face_b.c3;
        priority if (r_mask[dgt_pkg::SLOT_VTX]) begin
            o_record_kind   = dgt_pkg::REC_VERTEX;
            o_record_id     = dgt_pkg::FID_W'(r_bundle.vid);
            o_coord_x       = r_bundle.x;
            o_coord_y       = r_bundle.y;
            o_coord_z       = r_bundle.z;
            o_corner_first  = '0;
            o_corner_second = '0;
            o_corner_third  = '0;
        end else if (r_mask[dgt_pkg::SLOT_FACE_A]) begin
            o_record_id     = r_bundle.id_a;
            o_corner_first  = r_bundle.face_a.c1;
            o_corner_second = r_bundle.face_a.c2;
            o_corner_third  = r_bundle.face_a.c3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_load) begin
            r_mask <= i_bundle.mask;
        end else if (take) begin
            r_mask <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bundle <= i_bundle;
        end
    end

endmodule

[sv/depth_grid_triangulator_unit.sv]
// top level of the depth grid triangulator: apb step register and stage glue
// depends on dgt_pkg, dgt_vertex_stage, dgt_face_stage, dgt_record_out
//
// usage
// - input channel (i_in_valid / o_in_ready) takes one depth sample per grid point in
//   raster order; i_frame_start marks the first sample of a frame
// - output channel (o_out_valid / i_out_ready) gives vertex and face records; a sample
//   causes zero to three records, vertex first, o_last_of_item on the final one
// - apb port holds sample_step at byte address 0 (reset value 1, zero acts as one);
//   write it only while no transaction is in flight
// - path: an accepted sample is registered in the vertex stage, its records then in
//   the bundle register; throughput: one sample per cycle while each sample makes
//   at most one record and the receiver is ready; the output port sends one record
//   per ready cycle, so a vertex and two faces of a sample hold it, stalling the input
// - the row-above vertex ids live in a one-port-per-cycle memory of IMAGE_WIDTH
//   entries, read and written at the same column when a sample is accepted; it has
//   no clearing pass, entries are defined once the first grid row has passed
// - reset clears positions, counters and parity; a stalled receiver holds the
//   current record, and one more sample waits in the vertex stage before
//   o_in_ready drops
module depth_grid_triangulator_unit #(
    parameter int IMAGE_WIDTH  = dgt_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = dgt_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // apb configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dgt_pkg::ADDR_W-1:0]  paddr,
    input  logic [dgt_pkg::DATA_W-1:0]  pwdata,
    output logic [dgt_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // sample input
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [dgt_pkg::DEPTH_W-1:0] i_depth_value,
    input  logic                        i_frame_start,
    // record output
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_record_kind,
    output logic [dgt_pkg::FID_W-1:0]   o_record_id,
    output logic [dgt_pkg::X_W-1:0]     o_coord_x,
    output logic [dgt_pkg::Y_W-1:0]     o_coord_y,
    output logic signed [dgt_pkg::Z_W-1:0] o_coord_z,
    output logic [dgt_pkg::VID_W-1:0]   o_corner_first,
    output logic [dgt_pkg::VID_W-1:0]   o_corner_second,
    output logic [dgt_pkg::VID_W-1:0]   o_corner_third,
    output logic                        o_last_of_item
);

    logic [dgt_pkg::STEP_W-1:0] r_step;
    logic                       step_sel, cfg_write;
    logic                       r_s1_vld;
    logic                       accept, s1_adv, out_free;
    dgt_pkg::t_item             item;
    logic [dgt_pkg::VID_W-1:0]  above;
    dgt_pkg::t_bundle           bundle;

    // apb: register index is the word address
    assign pready    = 1'b1;
    assign step_sel  = (paddr[dgt_pkg::ADDR_W-1:2] == dgt_pkg::REG_SAMPLE_STEP);
    assign cfg_write = psel && penable && pwrite && pready && step_sel;
    assign prdata    = step_sel ? dgt_pkg::DATA_W'(r_step) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= dgt_pkg::STEP_RESET;
        end else if (cfg_write) begin
            r_step <= pwdata[dgt_pkg::STEP_W-1:0];
        end
    end

    // vertex stage holds one sample; it moves on once the output bundle frees up
    assign s1_adv     = r_s1_vld && out_free;
    assign o_in_ready = !r_s1_vld || s1_adv;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    dgt_vertex_stage #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_vertex (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_step        (r_step),
        .i_depth_value (i_depth_value),
        .i_frame_start (i_frame_start),
        .o_item        (item),
        .o_above       (above)
    );

    // faces are formed between the vertex stage register and the bundle register
    dgt_face_stage u_face (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (s1_adv),
        .i_item   (item),
        .i_above  (above),
        .o_bundle (bundle)
    );

    // samples that make no record pass without loading the bundle
    dgt_record_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (s1_adv && (bundle.mask != '0)),
        .i_bundle        (bundle),
        .i_out_ready     (i_out_ready),
        .o_free          (out_free),
        .o_out_valid     (o_out_valid),
        .o_record_kind   (o_record_kind),
        .o_record_id     (o_record_id),
        .o_coord_x       (o_coord_x),
        .o_coord_y       (o_coord_y),
        .o_coord_z       (o_coord_z),
        .o_corner_first  (o_corner_first),
        .o_corner_second (o_corner_second),
        .o_corner_third  (o_corner_third),
        .o_last_of_item  (o_last_of_item)
    );

    // vertex numbers never read as zero
    a_vertex_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_record_kind == dgt_pkg::REC_VERTEX) |-> o_record_id != '0)
        else $error("vertex record with id zero");

    // a face only comes out when all three corners exist
    a_face_corners: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_record_kind == dgt_pkg::REC_FACE) |->
            (o_corner_first != '0) && (o_corner_second != '0) && (o_corner_third != '0)
            && (o_record_id != '0))
        else $error("face record with missing corner or zero id");

    // a held sample blocks the input until it moves into the bundle
    a_stage_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !out_free |-> !o_in_ready)
        else $error("input taken while vertex stage is blocked");

    // a record that was not taken stays put
    a_record_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_record_id))
        else $error("pending record changed under stall");

endmodule
